### rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;
    localparam int CMD_W     = 3;
    localparam int OUT_W     = ((RES_NUM_W + RES_DEN_W + 2 + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

endpackage
`default_nettype wire

### rtl/rau_gcd_div.sv
`default_nettype none
module rau_gcd_div #(
    parameter int NW = 33
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [NW-1:0] den_in,
    output logic               done,
    output logic [NW-1:0]      num_out,
    output logic [NW-1:0]      den_out
);

    localparam int KW = (NW > 1) ? $clog2(NW) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV
    } state_t;

    state_t          state_reg;
    logic            done_reg;
    logic            sel_reg;
    logic [NW-1:0]   num_reg;
    logic [NW-1:0]   den_reg;
    logic [NW-1:0]   ga_reg;
    logic [NW-1:0]   gb_reg;
    logic [KW-1:0]   k_reg;
    logic [NW-1:0]   g_reg;
    logic [NW-1:0]   q_reg;
    logic [NW-1:0]   r_reg;
    logic [KW-1:0]   cnt_reg;
    logic [NW-1:0]   num_res_reg;
    logic [NW-1:0]   den_res_reg;

    logic            ga_gt;
    logic [NW-1:0]   diff;
    logic [NW:0]     trial;
    logic [NW:0]     trial_sub;
    logic            trial_ge;
    logic [NW-1:0]   q_next;

    always_comb
    begin
        ga_gt     = ga_reg > gb_reg;
        diff      = ga_gt ? (ga_reg - gb_reg) : (gb_reg - ga_reg);
        trial     = {r_reg, q_reg[NW-1]};
        trial_sub = trial - {1'b0, g_reg};
        trial_ge  = trial >= {1'b0, g_reg};
        q_next    = {q_reg[NW-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        num_reg   <= num_in;
                        den_reg   <= den_in;
                        ga_reg    <= num_in;
                        gb_reg    <= den_in;
                        k_reg     <= '0;
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD:
                begin
                    if (ga_reg == gb_reg)
                    begin
                        g_reg     <= ga_reg << k_reg;
                        q_reg     <= num_reg;
                        r_reg     <= '0;
                        cnt_reg   <= '0;
                        sel_reg   <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                    else if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        k_reg  <= k_reg + 1'b1;
                    end
                    else if (!ga_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                    end
                    else if (!gb_reg[0])
                    begin
                        gb_reg <= gb_reg >> 1;
                    end
                    else if (ga_gt)
                    begin
                        ga_reg <= diff >> 1;
                    end
                    else
                    begin
                        gb_reg <= diff >> 1;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == KW'(NW - 1))
                    begin
                        cnt_reg <= '0;
                        if (!sel_reg)
                        begin
                            num_res_reg <= q_next;
                            q_reg       <= den_reg;
                            r_reg       <= '0;
                            sel_reg     <= 1'b1;
                        end
                        else
                        begin
                            den_res_reg <= q_next;
                            done_reg    <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        r_reg   <= trial_ge ? trial_sub[NW-1:0] : trial[NW-1:0];
                        q_reg   <= q_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign num_out = num_res_reg;
    assign den_out = den_res_reg;

endmodule
`default_nettype wire

### rtl/rational_arith_unit_top.sv
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// fractions and return the result reduced to lowest terms.
// Input channel s_*: s_tuser carries the command, s_tdata the two operands.
// Output channel m_*: m_tdata carries the reduced fraction and compare flags,
// m_tuser the error flag (zero denominator or division by a zero fraction).
// One result transaction follows every input transaction, in order.
// s_tready is high only while the unit is idle; one item is in work at a time.
// Error and unused commands go straight to the output step. Compare forms the
// two cross products and compares them. Arithmetic forms up to three products
// in one OPERAND_WIDTH x OPERAND_WIDTH multiplier; a zero arithmetic result
// goes straight to the output step, and any other passes through the
// subtract-and-shift GCD loop and then the bit-serial restoring divider that
// divides numerator and denominator by the GCD.
// The result is held in an output register: s_tready rises in the cycle
// after the result moves there, even while it waits for m_tready.
// If the receiver stalls, a finished result waits in the last step
// until the output register frees, and s_tready stays low meanwhile.
// Reset (rst_n, asynchronous, active low) empties the unit and drops m_tvalid.
`default_nettype none
module rational_arith_unit_top #(
    parameter int OPERAND_WIDTH = 16,
    localparam int IN_W = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // a_numerator, a_denominator, b_numerator, b_denominator
    input  wire logic [IN_W-1:0]              s_tdata,
    // command
    input  wire logic [rau_pkg::CMD_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // result_numerator, result_denominator, is_greater, is_equal
    output logic [rau_pkg::OUT_W-1:0]         m_tdata,
    // error
    output logic                              m_tuser
);

    import rau_pkg::*;

    localparam int W    = OPERAND_WIDTH;
    localparam int PW   = 2 * W;
    localparam int NW   = 2 * W + 1;
    localparam int EW   = (NW > RES_NUM_W) ? NW + 1 : RES_NUM_W + 1;
    localparam int DEW  = (NW > RES_DEN_W) ? NW : RES_DEN_W;
    localparam int PADW = OUT_W - RES_NUM_W - RES_DEN_W - 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_D,
        ST_COMB,
        ST_REDUCE,
        ST_FIN
    } state_t;

    state_t                state_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic                  an_neg_reg;
    logic                  bn_neg_reg;
    logic [W-1:0]          an_reg;
    logic [W-1:0]          ad_reg;
    logic [W-1:0]          bn_reg;
    logic [W-1:0]          bd_reg;
    logic [PW-1:0]         x_reg;
    logic [PW-1:0]         y_reg;
    logic [PW-1:0]         d_reg;
    logic [NW-1:0]         mag_reg;
    logic [NW-1:0]         den_reg;
    logic                  neg_reg;
    logic                  gt_reg;
    logic                  eq_reg;
    logic                  err_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic                  m_tuser_reg;

    logic [W-1:0]          in_an_raw;
    logic [W-1:0]          in_ad;
    logic [W-1:0]          in_bn_raw;
    logic [W-1:0]          in_bd;
    logic                  in_an_neg;
    logic                  in_bn_neg;
    logic [W-1:0]          in_an_mag;
    logic [W-1:0]          in_bn_mag;

    logic [W-1:0]          mul_a;
    logic [W-1:0]          mul_b;
    logic [PW-1:0]         prod;

    logic                  xn;
    logic                  yn;
    logic                  yn_eff;
    logic                  cmp_gt;
    logic                  cmp_eq;
    logic [NW-1:0]         x_ext;
    logic [NW-1:0]         y_ext;
    logic [NW-1:0]         comb_mag;
    logic                  comb_neg;

    logic                  red_start;
    logic                  red_done;
    logic [NW-1:0]         red_num;
    logic [NW-1:0]         red_den;

    logic [EW-1:0]         num_ext;
    logic [EW-1:0]         num_signed;
    logic [DEW-1:0]        den_ext;
    logic                  out_free;

    always_comb
    begin
        in_an_raw = s_tdata[W-1:0];
        in_ad     = s_tdata[2*W-1:W];
        in_bn_raw = s_tdata[3*W-1:2*W];
        in_bd     = s_tdata[4*W-1:3*W];
        in_an_neg = in_an_raw[W-1];
        in_bn_neg = in_bn_raw[W-1];
        in_an_mag = in_an_neg ? (~in_an_raw + 1'b1) : in_an_raw;
        in_bn_mag = in_bn_neg ? (~in_bn_raw + 1'b1) : in_bn_raw;
    end

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL_Y:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            ST_MUL_D:
            begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        xn     = an_neg_reg && (x_reg != '0);
        yn     = bn_neg_reg && (y_reg != '0);
        cmp_eq = (xn == yn) && (x_reg == y_reg);
        if (xn != yn)
        begin
            cmp_gt = !xn;
        end
        else if (xn)
        begin
            cmp_gt = x_reg < y_reg;
        end
        else
        begin
            cmp_gt = x_reg > y_reg;
        end
        yn_eff = ((cmd_reg == CMD_SUB) && (y_reg != '0)) ? !yn : yn;
        x_ext  = NW'(x_reg);
        y_ext  = NW'(y_reg);
        if ((cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV))
        begin
            comb_mag = x_ext;
            comb_neg = an_neg_reg ^ bn_neg_reg;
        end
        else if (xn == yn_eff)
        begin
            comb_mag = x_ext + y_ext;
            comb_neg = xn;
        end
        else if (x_reg >= y_reg)
        begin
            comb_mag = x_ext - y_ext;
            comb_neg = xn;
        end
        else
        begin
            comb_mag = y_ext - x_ext;
            comb_neg = yn_eff;
        end
    end

    assign red_start = (state_reg == ST_COMB) && (cmd_reg != CMD_CMP) && (comb_mag != '0);

    rau_gcd_div #(
        .NW (NW)
    ) u_gcd_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .num_in  (comb_mag),
        .den_in  (NW'(d_reg)),
        .done    (red_done),
        .num_out (red_num),
        .den_out (red_den)
    );

    always_comb
    begin
        num_ext    = EW'(mag_reg);
        num_signed = neg_reg ? (~num_ext + 1'b1) : num_ext;
        den_ext    = DEW'(den_reg);
        out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= s_tuser;
                        an_reg     <= in_an_mag;
                        an_neg_reg <= in_an_neg;
                        bn_reg     <= in_bn_mag;
                        bn_neg_reg <= in_bn_neg;
                        ad_reg     <= in_ad;
                        bd_reg     <= in_bd;
                        mag_reg    <= '0;
                        den_reg    <= NW'(1);
                        neg_reg    <= 1'b0;
                        gt_reg     <= 1'b0;
                        eq_reg     <= 1'b0;
                        err_reg    <= 1'b0;
                        if (s_tuser > CMD_CMP)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else if ((in_ad == '0) || (in_bd == '0) ||
                                 ((s_tuser == CMD_DIV) && (in_bn_raw == '0)))
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_MUL_X;
                        end
                    end
                end
                ST_MUL_X:
                begin
                    x_reg <= prod;
                    if ((cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV))
                    begin
                        state_reg <= ST_MUL_D;
                    end
                    else
                    begin
                        state_reg <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y:
                begin
                    y_reg     <= prod;
                    state_reg <= (cmd_reg == CMD_CMP) ? ST_COMB : ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    d_reg     <= prod;
                    state_reg <= ST_COMB;
                end
                ST_COMB:
                begin
                    if (cmd_reg == CMD_CMP)
                    begin
                        gt_reg    <= cmp_gt;
                        eq_reg    <= cmp_eq;
                        state_reg <= ST_FIN;
                    end
                    else if (comb_mag == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        neg_reg   <= comb_neg;
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    if (red_done)
                    begin
                        mag_reg   <= red_num;
                        den_reg   <= red_den;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {{PADW{1'b0}}, eq_reg, gt_reg,
                                         den_ext[RES_DEN_W-1:0],
                                         num_signed[RES_NUM_W-1:0]};
                        m_tuser_reg  <= err_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire
